// File: src/mqotr_pkg.sv
// Shared types, codes and default sizes for the multi-queue trace ring.
// Used by the front, command queue, back and top modules and by the port checker.
package mqotr_pkg;

    // default sizes
    localparam int QUEUES_DEF       = 4;
    localparam int DEPTH_DEF        = 64;
    localparam int PAYLOAD_BITS_DEF = 64;

    // fixed field widths
    localparam int ACTION_W   = 1;
    localparam int QID_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int EN_W       = 4;
    localparam int CAP_REGS   = 4;
    localparam int CAP_W      = 7;
    localparam logic [CAP_W-1:0] CAP_RST = 7'd64;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;

    // actions
    localparam logic [ACTION_W-1:0] ACT_ENQ = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP3   = 3'd4;

    // store access the back performs for one word
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_WR   = 2'd1,
        OP_RD   = 2'd2
    } t_op;

    // classified result, handed from front to back
    typedef struct packed {
        t_op                 op;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occ;
        logic                ovw;
    } t_res;

endpackage

// File: src/mqotr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. No dependencies.
module mqotr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mqotr_front.sv
// Front end: config registers, per-queue pointers, and item classification.
// Depends on mqotr_pkg; pushes one command word per accepted item.
module mqotr_front #(
    parameter int QUEUES       = mqotr_pkg::QUEUES_DEF,
    parameter int DEPTH        = mqotr_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = mqotr_pkg::PAYLOAD_BITS_DEF,
    parameter int RAM_AW       = $clog2(QUEUES << $clog2(DEPTH))
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write channel
    input  logic                                i_cfg_valid,
    input  logic [mqotr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mqotr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mqotr_pkg::ACTION_W-1:0]      i_action,
    input  logic [mqotr_pkg::QID_W-1:0]         i_queue_id,
    input  logic [PAYLOAD_BITS-1:0]             i_write_data,
    // command queue push side
    input  logic                                i_cmdq_full,
    output logic                                o_push,
    output mqotr_pkg::t_res                     o_res,
    output logic [RAM_AW-1:0]                   o_addr,
    output logic [PAYLOAD_BITS-1:0]             o_data
);
    import mqotr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    // config registers
    logic [EN_W-1:0]  r_enable;
    logic [CAP_W-1:0] r_cap [CAP_REGS];

    // per-queue ring state
    logic [AW-1:0] r_head [QUEUES];
    logic [AW-1:0] r_tail [QUEUES];
    logic [CW-1:0] r_cnt  [QUEUES];

    logic [QW-1:0]    qi;
    logic             in_rng;
    logic             en;
    logic [CAP_W-1:0] cap_raw;
    logic [CW-1:0]    cap_eff;
    logic [AW-1:0]    head;
    logic [AW-1:0]    tail;
    logic [CW-1:0]    cnt;
    logic [CW-1:0]    head_p1;
    logic [CW-1:0]    tail_p1;
    logic [AW-1:0]    head_inc;
    logic [AW-1:0]    tail_inc;
    logic             full;
    logic             accept;
    logic [AW-1:0]    n_head;
    logic [AW-1:0]    n_tail;
    logic [CW-1:0]    n_cnt;
    logic             upd;
    logic [AW-1:0]    ptr;
    logic [CFG_IDX_W-1:0] cap_sel;

    assign o_in_stall = i_cmdq_full;
    assign accept     = i_in_valid && !i_cmdq_full;
    assign o_push     = accept;

    // lookup of the addressed queue
    always_comb begin
        qi      = QW'(i_queue_id);
        in_rng  = int'(i_queue_id) < QUEUES;
        en      = in_rng && r_enable[i_queue_id];
        cap_raw = r_cap[i_queue_id];
        if (cap_raw == '0) begin
            cap_eff = CW'(1);
        end else if (int'(cap_raw) > DEPTH) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(cap_raw);
        end
        head     = r_head[qi];
        tail     = r_tail[qi];
        cnt      = r_cnt[qi];
        head_p1  = CW'(head) + CW'(1);
        tail_p1  = CW'(tail) + CW'(1);
        head_inc = (head_p1 == cap_eff) ? '0 : AW'(head_p1);
        tail_inc = (tail_p1 == cap_eff) ? '0 : AW'(tail_p1);
        full     = (cnt == cap_eff);
    end

    // classify the item and work out the queue's next pointers
    always_comb begin
        n_head     = head;
        n_tail     = tail;
        n_cnt      = cnt;
        upd        = 1'b0;
        ptr        = tail;
        o_res.op     = OP_NONE;
        o_res.status = ST_DONE;
        o_res.occ    = '0;
        o_res.ovw    = 1'b0;
        if (!en) begin
            o_res.status = ST_DISABLED;
            o_res.occ    = in_rng ? OCC_W'(cnt) : '0;
        end else if (i_action == ACT_ENQ) begin
            // full queue: drop the oldest before writing
            upd       = 1'b1;
            ptr       = tail;
            n_tail    = tail_inc;
            n_head    = full ? head_inc : head;
            n_cnt     = full ? cnt : cnt + CW'(1);
            o_res.op  = OP_WR;
            o_res.ovw = full;
            o_res.occ = OCC_W'(n_cnt);
        end else if (cnt == '0) begin
            o_res.status = ST_EMPTY;
        end else begin
            upd       = 1'b1;
            ptr       = head;
            n_head    = head_inc;
            n_cnt     = cnt - CW'(1);
            o_res.op  = OP_RD;
            o_res.occ = OCC_W'(n_cnt);
        end
        o_addr = RAM_AW'({qi, ptr});
        o_data = i_write_data;
    end

    assign cap_sel = i_cfg_index - CFG_CAP0;

    // register file and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            for (int c = 0; c < CAP_REGS; c++) begin
                r_cap[c] <= CAP_RST;
            end
            for (int q = 0; q < QUEUES; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_cnt[q]  <= '0;
            end
        end else begin
            if (accept && upd) begin
                r_head[qi] <= n_head;
                r_tail[qi] <= n_tail;
                r_cnt[qi]  <= n_cnt;
            end
            // config must only be written while idle; the block does not enforce this
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ENABLE) begin
                    r_enable <= i_cfg_data[EN_W-1:0];
                end else if (i_cfg_index <= CFG_CAP3) begin
                    r_cap[cap_sel[QID_W-1:0]] <= i_cfg_data;
                    if (int'(cap_sel[QID_W-1:0]) < QUEUES) begin
                        r_head[QW'(cap_sel[QID_W-1:0])] <= '0;
                        r_tail[QW'(cap_sel[QID_W-1:0])] <= '0;
                        r_cnt[QW'(cap_sel[QID_W-1:0])]  <= '0;
                    end
                end
            end
        end
    end

endmodule

// File: src/mqotr_cmdq.sv
// Short command queue between front and back, built from flops.
// Depends on mqotr_pkg for its depth.
module mqotr_cmdq #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);
    import mqotr_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);

    logic [WIDTH-1:0] r_slot [CMDQ_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic [PW:0]      n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_slot[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: src/mqotr_back.sv
// Back end: entry store access and the output register toward the receiver.
// Depends on mqotr_pkg and mqotr_ram.
module mqotr_back #(
    parameter int QUEUES       = mqotr_pkg::QUEUES_DEF,
    parameter int DEPTH        = mqotr_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = mqotr_pkg::PAYLOAD_BITS_DEF,
    parameter int RAM_AW       = $clog2(QUEUES << $clog2(DEPTH))
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command queue pop side
    input  logic                             i_cmd_empty,
    input  mqotr_pkg::t_res                  i_res,
    input  logic [RAM_AW-1:0]                i_addr,
    input  logic [PAYLOAD_BITS-1:0]          i_data,
    output logic                             o_pop,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [mqotr_pkg::STATUS_W-1:0]   o_status,
    output logic [PAYLOAD_BITS-1:0]          o_read_data,
    output logic [mqotr_pkg::OCC_W-1:0]      o_occupancy,
    output logic                             o_overwrote
);
    import mqotr_pkg::*;

    localparam int RAM_DEPTH = QUEUES << $clog2(DEPTH);

    logic                    r_s1_vld;
    t_res                    r_s1_res;
    logic                    r_o_vld;
    logic [STATUS_W-1:0]     r_status;
    logic [PAYLOAD_BITS-1:0] r_rdata;
    logic [OCC_W-1:0]        r_occ;
    logic                    r_ovw;
    logic [PAYLOAD_BITS-1:0] ram_rdata;
    logic                    s1_adv;
    logic                    we;
    logic                    re;

    // a word leaves the store stage when the output slot frees up
    assign s1_adv = !r_o_vld || !i_out_stall;
    assign o_pop  = !i_cmd_empty && (!r_s1_vld || s1_adv);
    assign we     = o_pop && (i_res.op == OP_WR);
    assign re     = o_pop && (i_res.op == OP_RD);

    mqotr_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_addr),
        .i_wdata (i_data),
        .i_re    (re),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    // store stage: result fields wait here for the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_pop) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_res <= i_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_status <= r_s1_res.status;
            r_occ    <= r_s1_res.occ;
            r_ovw    <= r_s1_res.ovw;
            r_rdata  <= (r_s1_res.op == OP_RD) ? ram_rdata : '0;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_status    = r_status;
    assign o_read_data = r_rdata;
    assign o_occupancy = r_occ;
    assign o_overwrote = r_ovw;

endmodule

// File: src/multi_queue_overwrite_trace_ring_top.sv
// Multi-queue overwrite-oldest trace ring, top level.
// Usage:
//   Items enter on the input channel (i_in_valid / o_in_stall) with an action,
//   a queue id and a payload. Each item gives exactly one result word on the
//   output channel (o_out_valid / i_out_stall): status, read data, occupancy
//   after the item and an overwrite flag.
//   Enqueue to a full queue drops its oldest entry; dequeue returns the oldest.
//   Registers are written on the cfg channel (o_cfg_ready is always high):
//   index 0 is the queue enable mask, 1..4 the capacities of queues 0..3.
//   A capacity write empties that queue. Write registers only while idle.
// Timing:
//   An item passes the command queue, store stage and output register in order.
//   Throughput is one item per cycle while i_out_stall is low: the front
//   classifies and updates pointers in the accept cycle, the back does one
//   entry store access per cycle. A 4-word command queue sits between front
//   and back; a stalled receiver fills it and o_in_stall rises once it is full.
// Reset: synchronous, active low. Queues empty, all disabled, capacities 64.
//   Store contents are not cleared; entry reads are guarded by the counts.
// Depends on mqotr_pkg, mqotr_front, mqotr_cmdq, mqotr_back.
module multi_queue_overwrite_trace_ring_top #(
    parameter int QUEUES       = mqotr_pkg::QUEUES_DEF,
    parameter int DEPTH        = mqotr_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = mqotr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mqotr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mqotr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // item channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mqotr_pkg::ACTION_W-1:0]   i_action,
    input  logic [mqotr_pkg::QID_W-1:0]      i_queue_id,
    input  logic [PAYLOAD_BITS-1:0]          i_write_data,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [mqotr_pkg::STATUS_W-1:0]   o_status,
    output logic [PAYLOAD_BITS-1:0]          o_read_data,
    output logic [mqotr_pkg::OCC_W-1:0]      o_occupancy,
    output logic                             o_overwrote
);
    import mqotr_pkg::*;

    localparam int RAM_AW = $clog2(QUEUES << $clog2(DEPTH));
    localparam int RES_W  = $bits(t_res);
    localparam int CMD_W  = RES_W + RAM_AW + PAYLOAD_BITS;

    logic                    cmdq_full;
    logic                    cmdq_empty;
    logic                    push;
    logic                    pop;
    t_res                    f_res;
    logic [RAM_AW-1:0]       f_addr;
    logic [PAYLOAD_BITS-1:0] f_data;
    logic [CMD_W-1:0]        q_word;
    t_res                    b_res;
    logic [RAM_AW-1:0]       b_addr;
    logic [PAYLOAD_BITS-1:0] b_data;

    assign o_cfg_ready = 1'b1;

    mqotr_front #(
        .QUEUES       (QUEUES),
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .RAM_AW       (RAM_AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_queue_id   (i_queue_id),
        .i_write_data (i_write_data),
        .i_cmdq_full  (cmdq_full),
        .o_push       (push),
        .o_res        (f_res),
        .o_addr       (f_addr),
        .o_data       (f_data)
    );

    mqotr_cmdq #(
        .WIDTH (CMD_W)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_res, f_addr, f_data}),
        .o_full  (cmdq_full),
        .i_pop   (pop),
        .o_empty (cmdq_empty),
        .o_rdata (q_word)
    );

    assign {b_res, b_addr, b_data} = q_word;

    mqotr_back #(
        .QUEUES       (QUEUES),
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .RAM_AW       (RAM_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmdq_empty),
        .i_res       (b_res),
        .i_addr      (b_addr),
        .i_data      (b_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_read_data (o_read_data),
        .o_occupancy (o_occupancy),
        .o_overwrote (o_overwrote)
    );

endmodule

// File: src/mqotr_checker.sv
// Port-level checker for the trace ring, bound onto the top level.
// Depends on mqotr_pkg for status codes.
module mqotr_checker #(
    parameter int PAYLOAD_BITS = mqotr_pkg::PAYLOAD_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [mqotr_pkg::STATUS_W-1:0] o_status,
    input logic [PAYLOAD_BITS-1:0]        o_read_data,
    input logic [mqotr_pkg::OCC_W-1:0]    o_occupancy,
    input logic                           o_overwrote
);
    import mqotr_pkg::*;

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data)
            && $stable(o_status) && $stable(o_occupancy))
        else $error("result word changed under stall");

    // only a successful item carries data or an overwrite
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_read_data == '0 && !o_overwrote)
        else $error("failed item carries data or overwrite");

    // an overwrite leaves the queue holding at least one entry
    a_ovw_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overwrote |-> o_status == ST_DONE && o_occupancy != '0)
        else $error("overwrite with empty queue");

    // empty dequeue reports zero occupancy
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_occupancy == '0)
        else $error("empty status with entries left");

    // status code is never the unused value
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_DONE || o_status == ST_DISABLED
            || o_status == ST_EMPTY)
        else $error("unused status code");

endmodule

bind multi_queue_overwrite_trace_ring_top mqotr_checker #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_mqotr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_read_data (o_read_data),
    .o_occupancy (o_occupancy),
    .o_overwrote (o_overwrote)
);
